@@ hdl/assert_macros.svh @@
// Assertion macros used by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TFP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define TFP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ hdl/tfp_pkg.sv @@
// Types and constants shared by the TLV frame parser modules.
package tfp_pkg;

    localparam int unsigned POS_W = 17;
    localparam int unsigned ACC_W = 48;

    // header byte offsets
    localparam logic [POS_W-1:0] CHECK_START = 17'd2;
    localparam logic [POS_W-1:0] BODY_START  = 17'd5;
    localparam logic [POS_W-1:0] MSG_POS     = 17'd2;
    localparam logic [POS_W-1:0] LEN_HI_POS  = 17'd3;
    localparam logic [POS_W-1:0] LEN_LO_POS  = 17'd4;
    localparam logic [POS_W-1:0] LEN_ADJ     = 17'd6;

    localparam logic [7:0] NUM_BYTES  = 8'd4;
    localparam logic [7:0] TIME_BYTES = 8'd6;

    localparam logic [2:0] TYPE_NUM0 = 3'd0;
    localparam logic [2:0] TYPE_NUM1 = 3'd1;
    localparam logic [2:0] TYPE_STR  = 3'd2;
    localparam logic [2:0] TYPE_TIME = 3'd3;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_HEAD   = 3'd1,
        PH_NAME   = 3'd2,
        PH_STRLEN = 3'd3,
        PH_VALUE  = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        KIND_HEADER   = 3'd0,
        KIND_HEAD     = 3'd1,
        KIND_NAME     = 3'd2,
        KIND_STRLEN   = 3'd3,
        KIND_VALUE    = 3'd4,
        KIND_CHECKSUM = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        ST_BUSY = 2'd0,
        ST_OK   = 2'd1,
        ST_BAD  = 2'd2,
        ST_CUT  = 2'd3
    } t_status;

    typedef struct packed {
        t_kind             byte_kind;
        logic [7:0]        echo_byte;
        logic [2:0]        item_type;
        logic [4:0]        name_length;
        logic [ACC_W-1:0]  value_word;
        logic              value_complete;
        logic [2:0]        message_kind;
        logic              frame_end;
        t_status           frame_status;
    } t_result;

endpackage

@@ hdl/tlv_frame_parser_xor.sv @@
// Top level of the TLV frame parser with XOR checksum check.
//
// Slave stream: one frame byte per request in i_s_axis_tdata. The first byte
// after reset or after a checksum byte is byte 0 of a new frame. Bytes 3..4
// give the payload length; the frame is that plus 6 bytes, the last one being
// the XOR of bytes 2 up to the byte before it.
// Master stream: one result per input byte. tlast marks the checksum byte,
// tuser carries the byte kind and the value-complete flag, tdata the echoed
// byte, item type, name length, assembled value, message type and status.
// A byte accepted on the slave side passes the input register, then the result
// register, before it shows up on the master side.
// Throughput: one byte per cycle unless the master side stalls; the whole
// parse step is one pass of logic between the input and result registers.
// Stall: when the master side stalls, the result register holds and the input
// register still takes one more byte; tready drops only with both full.
// Reset (i_rst_n low, synchronous) empties both registers and returns the
// parser to the start of a frame.
module tlv_frame_parser_xor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] in_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] echo_byte, [10:8] item_type, [15:11] name_length,
    // [63:16] value_word, [66:64] message_kind, [68:67] frame_status, [71:69] zero
    output logic [71:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast,   // frame_end
    output logic [3:0]  o_m_axis_tuser    // [2:0] byte_kind, [3] value_complete
);

    logic             in_valid;
    logic [7:0]       in_byte;
    logic             out_ready;
    logic             fire;
    tfp_pkg::t_result res;

    assign fire = in_valid && out_ready;

    tfp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_byte  (i_s_axis_tdata),
        .o_ready (o_s_axis_tready),
        .i_take  (out_ready),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    tfp_parser u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fire),
        .i_byte  (in_byte),
        .o_res   (res)
    );

    tfp_out_stage u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (in_valid),
        .i_res           (res),
        .o_ready         (out_ready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

@@ hdl/tfp_in_stage.sv @@
// Input register stage: holds one request byte until the parser takes it.
module tfp_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    output logic       o_ready,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

endmodule

@@ hdl/tfp_parser.sv @@
// Frame parse state and the per-byte result logic.
`include "assert_macros.svh"

module tfp_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    output tfp_pkg::t_result  o_res
);

    logic [tfp_pkg::POS_W-1:0] r_pos,   n_pos;
    logic [tfp_pkg::POS_W-1:0] r_flen,  n_flen;
    logic [7:0]                r_xor,   n_xor;
    tfp_pkg::t_phase           r_phase, n_phase;
    logic [7:0]                r_bl,    n_bl;
    logic [2:0]                r_type,  n_type;
    logic [4:0]                r_nlen,  n_nlen;
    logic [tfp_pkg::ACC_W-1:0] r_acc,   n_acc;
    logic [2:0]                r_msg,   n_msg;

    logic [tfp_pkg::POS_W:0]   pos_inc;
    logic                      is_ck;
    logic [7:0]                bl_dec;

    // phase after the name bytes of an item of the given type
    function automatic tfp_pkg::t_phase after_name_phase(input logic [2:0] typ);
        tfp_pkg::t_phase ph;
        case (typ)
            tfp_pkg::TYPE_NUM0, tfp_pkg::TYPE_NUM1, tfp_pkg::TYPE_TIME: ph = tfp_pkg::PH_VALUE;
            tfp_pkg::TYPE_STR:  ph = tfp_pkg::PH_STRLEN;
            default:            ph = tfp_pkg::PH_HEAD;
        endcase
        return ph;
    endfunction

    // value byte count after the name; other types leave the count alone
    function automatic logic [7:0] after_name_count(input logic [2:0] typ,
                                                     input logic [7:0] cur);
        logic [7:0] cnt;
        case (typ)
            tfp_pkg::TYPE_NUM0, tfp_pkg::TYPE_NUM1: cnt = tfp_pkg::NUM_BYTES;
            tfp_pkg::TYPE_TIME: cnt = tfp_pkg::TIME_BYTES;
            default:            cnt = cur;
        endcase
        return cnt;
    endfunction

    assign pos_inc = {1'b0, r_pos} + 18'd1;
    assign is_ck   = (r_pos >= tfp_pkg::BODY_START) && (pos_inc == {1'b0, r_flen});
    assign bl_dec  = r_bl - 8'd1;

    always_comb begin
        n_pos   = r_pos;
        n_flen  = r_flen;
        n_xor   = r_xor;
        n_phase = r_phase;
        n_bl    = r_bl;
        n_type  = r_type;
        n_nlen  = r_nlen;
        n_acc   = r_acc;
        n_msg   = r_msg;

        o_res                = '0;
        o_res.byte_kind      = tfp_pkg::KIND_HEADER;
        o_res.frame_status   = tfp_pkg::ST_BUSY;
        o_res.echo_byte      = i_byte;

        if (is_ck) begin
            o_res.byte_kind    = tfp_pkg::KIND_CHECKSUM;
            o_res.frame_end    = 1'b1;
            o_res.message_kind = r_msg;
            // a mismatch wins over a cut item
            if (r_xor != i_byte) begin
                o_res.frame_status = tfp_pkg::ST_BAD;
            end else if (r_phase != tfp_pkg::PH_HEAD) begin
                o_res.frame_status = tfp_pkg::ST_CUT;
            end else begin
                o_res.frame_status = tfp_pkg::ST_OK;
            end
            n_pos   = '0;
            n_flen  = '0;
            n_xor   = '0;
            n_phase = tfp_pkg::PH_HEADER;
            n_bl    = '0;
            n_type  = '0;
            n_nlen  = '0;
            n_acc   = '0;
            n_msg   = '0;
        end else begin
            if (r_pos >= tfp_pkg::CHECK_START) begin
                n_xor = r_xor ^ i_byte;
            end
            if (r_pos < tfp_pkg::BODY_START) begin
                o_res.byte_kind = tfp_pkg::KIND_HEADER;
                if (r_pos == tfp_pkg::MSG_POS) begin
                    n_msg = i_byte[7:5];
                end
                if (r_pos == tfp_pkg::LEN_HI_POS) begin
                    n_flen = {1'b0, i_byte, 8'h00};
                end
                if (r_pos == tfp_pkg::LEN_LO_POS) begin
                    n_flen  = r_flen + {9'd0, i_byte} + tfp_pkg::LEN_ADJ;
                    n_phase = tfp_pkg::PH_HEAD;
                end
            end else begin
                case (r_phase)
                    tfp_pkg::PH_NAME: begin
                        o_res.byte_kind = tfp_pkg::KIND_NAME;
                        n_bl = bl_dec;
                        if (bl_dec == 8'd0) begin
                            n_phase = after_name_phase(r_type);
                            n_bl    = after_name_count(r_type, bl_dec);
                        end
                    end
                    tfp_pkg::PH_STRLEN: begin
                        o_res.byte_kind = tfp_pkg::KIND_STRLEN;
                        n_bl    = i_byte;
                        n_phase = (i_byte == 8'd0) ? tfp_pkg::PH_HEAD : tfp_pkg::PH_VALUE;
                    end
                    tfp_pkg::PH_VALUE: begin
                        o_res.byte_kind = tfp_pkg::KIND_VALUE;
                        if (r_type != tfp_pkg::TYPE_STR) begin
                            n_acc = {r_acc[tfp_pkg::ACC_W-9:0], i_byte};
                        end
                        n_bl = bl_dec;
                        if (bl_dec == 8'd0) begin
                            if (r_type != tfp_pkg::TYPE_STR) begin
                                o_res.value_complete = 1'b1;
                                o_res.value_word     = n_acc;
                            end
                            n_phase = tfp_pkg::PH_HEAD;
                        end
                    end
                    default: begin
                        // item head; also taken in the header phase
                        o_res.byte_kind = tfp_pkg::KIND_HEAD;
                        n_type = i_byte[7:5];
                        n_nlen = i_byte[4:0];
                        n_acc  = '0;
                        if (i_byte[4:0] != 5'd0) begin
                            n_phase = tfp_pkg::PH_NAME;
                            n_bl    = {3'd0, i_byte[4:0]};
                        end else begin
                            n_phase = after_name_phase(i_byte[7:5]);
                            n_bl    = after_name_count(i_byte[7:5], r_bl);
                        end
                    end
                endcase
                o_res.item_type   = n_type;
                o_res.name_length = n_nlen;
            end
            n_pos              = pos_inc[tfp_pkg::POS_W-1:0];
            o_res.message_kind = n_msg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_flen  <= '0;
            r_xor   <= '0;
            r_phase <= tfp_pkg::PH_HEADER;
            r_bl    <= '0;
            r_type  <= '0;
            r_nlen  <= '0;
            r_acc   <= '0;
            r_msg   <= '0;
        end else if (i_valid) begin
            r_pos   <= n_pos;
            r_flen  <= n_flen;
            r_xor   <= n_xor;
            r_phase <= n_phase;
            r_bl    <= n_bl;
            r_type  <= n_type;
            r_nlen  <= n_nlen;
            r_acc   <= n_acc;
            r_msg   <= n_msg;
        end
    end

    // checksum byte returns the parser to its reset state
    `TFP_ASSERT_NXT(a_ck_clears, i_clk, i_rst_n, i_valid && is_ck, r_pos == '0 && r_xor == '0 && r_phase == tfp_pkg::PH_HEADER)
    // only numeric and timestamp items complete a value
    `TFP_ASSERT_NOW(a_vc_type, i_clk, i_rst_n, i_valid && o_res.value_complete, r_type == tfp_pkg::TYPE_NUM0 || r_type == tfp_pkg::TYPE_NUM1 || r_type == tfp_pkg::TYPE_TIME)
    // once in the body the header phase is never seen
    `TFP_ASSERT_NOW(a_body_phase, i_clk, i_rst_n, r_pos >= tfp_pkg::BODY_START, r_phase != tfp_pkg::PH_HEADER)

endmodule

@@ hdl/tfp_out_stage.sv @@
// Result register stage driving the master stream.
module tfp_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  tfp_pkg::t_result  i_res,
    output logic              o_ready,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [71:0]       o_m_axis_tdata,
    output logic              o_m_axis_tlast,
    output logic [3:0]        o_m_axis_tuser
);

    logic             r_valid;
    tfp_pkg::t_result r_res;

    assign o_ready         = !r_valid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tlast  = r_res.frame_end;
    assign o_m_axis_tuser  = {r_res.value_complete, r_res.byte_kind};
    assign o_m_axis_tdata  = {3'd0, r_res.frame_status, r_res.message_kind,
                              r_res.value_word, r_res.name_length,
                              r_res.item_type, r_res.echo_byte};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end

endmodule
